FILE: rtl/core/bmp32_stream_decoder_assert.svh
// assertion macros for the bmp32 stream decoder
// used by the top level only, no other dependencies
`ifndef BMP32_STREAM_DECODER_ASSERT_SVH
`define BMP32_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BMP32_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmp32 assertion failed");

// next-cycle implication, disabled in reset
`define BMP32_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmp32 assertion failed");

`endif

FILE: rtl/core/bmp32_pkg.sv
// shared types and constants for the bmp32 stream decoder
// no dependencies
`default_nettype none

package bmp32_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W  = 11;
  localparam int ADDR_W = 20;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [5:0]  HDR_BYTES   = 6'd54;
  localparam logic [15:0] SIG_BM      = 16'h4D42;
  localparam logic [31:0] INFO_MIN    = 32'd40;
  localparam logic [15:0] BPP_32      = 16'd32;

  localparam logic [5:0] OFS_BASE   = 6'd10;
  localparam logic [5:0] INFO_BASE  = 6'd14;
  localparam logic [5:0] WID_BASE   = 6'd18;
  localparam logic [5:0] HGT_BASE   = 6'd22;
  localparam logic [5:0] PLN_BASE   = 6'd26;
  localparam logic [5:0] BPP_BASE   = 6'd28;
  localparam logic [5:0] CMP_BASE   = 6'd30;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    ST_PIXEL,
    ST_TRUNC,
    ST_SIG,
    ST_HDR,
    ST_DIM,
    ST_COMP,
    ST_BIG,
    ST_OFS
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [31:0]        pixel;
    logic [DIM_W-1:0]   drow;
    logic [DIM_W-1:0]   col;
    logic               last;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/bmp32_front.sv
// front end: header capture and checks, offset skip, pixel assembly
// depends on bmp32_pkg, pushes work entries into bmp32_fifo
`default_nettype none

module bmp32_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_end_of_file,
  input  wire logic              q_full,
  output logic                   q_push,
  output bmp32_pkg::entry_t      q_entry
);
  import bmp32_pkg::*;

  function automatic logic [31:0] put_byte(input logic [31:0] field, input logic [7:0] b,
                                           input logic [1:0] lane);
    logic [31:0] res;
    res = field;
    res[{lane, 3'b000} +: 8] = b;
    return res;
  endfunction

  phase_t phase_r, phase_nxt;
  logic [5:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [23:0] part_r, part_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic flip_r, flip_nxt;
  logic [DIM_W-1:0] w_r, w_nxt;
  logic [DIM_W-1:0] h_r, h_nxt;

  logic [15:0] sig_r, sig_nxt;
  logic [31:0] ofs_r, ofs_nxt;
  logic [31:0] info_r, info_nxt;
  logic [31:0] wid_r, wid_nxt;
  logic [31:0] hgt_r, hgt_nxt;
  logic [15:0] pln_r, pln_nxt;
  logic [15:0] bpp_r, bpp_nxt;
  logic [31:0] cmp_r, cmp_nxt;

  logic        accept;
  logic        eof;
  logic        hdr_done;
  logic        pix_done;
  logic        last_pix;
  logic [31:0] abs_h;
  status_t     chk;
  logic [DIM_W-1:0] drow;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign eof      = in_end_of_file;
  assign hdr_done = (hdr_cnt_r == HDR_BYTES - 6'd1);
  assign pix_done = (bip_r == 2'd3);
  assign last_pix = (row_r + DIM_W'(1) == h_r) && (col_r + DIM_W'(1) == w_r);
  assign abs_h    = hgt_r[31] ? (32'd0 - hgt_r) : hgt_r;
  assign drow     = flip_r ? (h_r - DIM_W'(1) - row_r) : row_r;

  // header checks, the first failing check sets the status
  always_comb begin
    chk = ST_PIXEL;
    if (sig_r != SIG_BM) begin
      chk = ST_SIG;
    end else if (info_r < INFO_MIN || pln_r != 16'd1 || bpp_r != BPP_32) begin
      chk = ST_HDR;
    end else if (wid_r[31] || wid_r == 32'd0 || hgt_r == 32'd0) begin
      chk = ST_DIM;
    end else if (cmp_r != 32'd0) begin
      chk = ST_COMP;
    end else if (wid_r > 32'(MAX_WIDTH) || abs_h > 32'(MAX_HEIGHT)) begin
      chk = ST_BIG;
    end else if (ofs_r < 32'(HDR_BYTES)) begin
      chk = ST_OFS;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (eof) begin
        phase_nxt = PH_HEADER;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hdr_done) begin
              if (chk != ST_PIXEL) begin
                phase_nxt = PH_DRAIN;
              end else if (32'(HDR_BYTES) >= ofs_r) begin
                phase_nxt = PH_PIXEL;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            if (pos_r + 32'd1 >= ofs_r) begin
              phase_nxt = PH_PIXEL;
            end
          end
          PH_PIXEL: begin
            if (pix_done && last_pix) begin
              phase_nxt = PH_DRAIN;
            end
          end
          PH_DRAIN: begin
            phase_nxt = PH_DRAIN;
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
    end
  end

  // queue push and entry
  always_comb begin
    q_push         = 1'b0;
    q_entry        = '0;
    q_entry.status = ST_TRUNC;
    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_done && chk != ST_PIXEL) begin
            q_push         = 1'b1;
            q_entry.status = chk;
          end else begin
            q_push = eof;
          end
        end
        PH_SKIP: begin
          q_push = eof;
        end
        PH_PIXEL: begin
          if (!pix_done || (eof && !last_pix)) begin
            q_push = eof;
          end else begin
            q_push         = 1'b1;
            q_entry.status = ST_PIXEL;
            q_entry.pixel  = {in_data_byte, part_r};
            q_entry.drow   = drow;
            q_entry.col    = col_r;
            q_entry.last   = last_pix;
            q_entry.width  = w_r;
            q_entry.height = h_r;
          end
        end
        PH_DRAIN: begin
          q_push = 1'b0;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  // header field capture
  always_comb begin
    sig_nxt  = sig_r;
    ofs_nxt  = ofs_r;
    info_nxt = info_r;
    wid_nxt  = wid_r;
    hgt_nxt  = hgt_r;
    pln_nxt  = pln_r;
    bpp_nxt  = bpp_r;
    cmp_nxt  = cmp_r;
    if (accept && phase_r == PH_HEADER) begin
      case (hdr_cnt_r) inside
        6'd0: sig_nxt[7:0] = in_data_byte;
        6'd1: sig_nxt[15:8] = in_data_byte;
        [OFS_BASE:OFS_BASE + 6'd3]:
          ofs_nxt = put_byte(ofs_r, in_data_byte, 2'(hdr_cnt_r - OFS_BASE));
        [INFO_BASE:INFO_BASE + 6'd3]:
          info_nxt = put_byte(info_r, in_data_byte, 2'(hdr_cnt_r - INFO_BASE));
        [WID_BASE:WID_BASE + 6'd3]:
          wid_nxt = put_byte(wid_r, in_data_byte, 2'(hdr_cnt_r - WID_BASE));
        [HGT_BASE:HGT_BASE + 6'd3]:
          hgt_nxt = put_byte(hgt_r, in_data_byte, 2'(hdr_cnt_r - HGT_BASE));
        [PLN_BASE:PLN_BASE + 6'd1]:
          pln_nxt = 16'(put_byte({16'd0, pln_r}, in_data_byte, 2'(hdr_cnt_r - PLN_BASE)));
        [BPP_BASE:BPP_BASE + 6'd1]:
          bpp_nxt = 16'(put_byte({16'd0, bpp_r}, in_data_byte, 2'(hdr_cnt_r - BPP_BASE)));
        [CMP_BASE:CMP_BASE + 6'd3]:
          cmp_nxt = put_byte(cmp_r, in_data_byte, 2'(hdr_cnt_r - CMP_BASE));
        default: ;
      endcase
    end
  end

  // counters and pixel assembly
  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    pos_nxt     = pos_r;
    bip_nxt     = bip_r;
    part_nxt    = part_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    flip_nxt    = flip_r;
    w_nxt       = w_r;
    h_nxt       = h_r;
    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          hdr_cnt_nxt = hdr_cnt_r + 6'd1;
          if (hdr_done) begin
            pos_nxt  = 32'(HDR_BYTES);
            flip_nxt = !hgt_r[31];
            w_nxt    = wid_r[DIM_W-1:0];
            h_nxt    = abs_h[DIM_W-1:0];
          end
        end
        PH_SKIP: begin
          pos_nxt = pos_r + 32'd1;
        end
        PH_PIXEL: begin
          if (!pix_done) begin
            part_nxt[{bip_r, 3'b000} +: 8] = in_data_byte;
            bip_nxt = bip_r + 2'd1;
          end else begin
            bip_nxt = 2'd0;
            if (col_r + DIM_W'(1) >= w_r) begin
              col_nxt = '0;
              row_nxt = row_r + DIM_W'(1);
            end else begin
              col_nxt = col_r + DIM_W'(1);
            end
          end
        end
        default: ;
      endcase
      if (eof) begin
        hdr_cnt_nxt = '0;
        pos_nxt     = '0;
        bip_nxt     = '0;
        row_nxt     = '0;
        col_nxt     = '0;
        flip_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      pos_r     <= '0;
      bip_r     <= '0;
      row_r     <= '0;
      col_r     <= '0;
      flip_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      pos_r     <= pos_nxt;
      bip_r     <= bip_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      flip_r    <= flip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    sig_r  <= sig_nxt;
    ofs_r  <= ofs_nxt;
    info_r <= info_nxt;
    wid_r  <= wid_nxt;
    hgt_r  <= hgt_nxt;
    pln_r  <= pln_nxt;
    bpp_r  <= bpp_nxt;
    cmp_r  <= cmp_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/bmp32_fifo.sv
// short work queue between front and back end
// depends on bmp32_pkg for the entry type and depth
`default_nettype none

module bmp32_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bmp32_pkg::entry_t push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output bmp32_pkg::entry_t      head
);
  import bmp32_pkg::*;

  entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (Q_AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (Q_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bmp32_back.sv
// back end: destination address multiply and result output register
// depends on bmp32_pkg, takes entries from bmp32_fifo
`default_nettype none

module bmp32_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire bmp32_pkg::entry_t             q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_status,
  output logic [31:0]                        out_pixel_value,
  output logic [bmp32_pkg::ADDR_W-1:0]       out_pixel_address,
  output logic                               out_last_pixel,
  output logic [bmp32_pkg::DIM_W-1:0]        out_image_width,
  output logic [bmp32_pkg::DIM_W-1:0]        out_image_height
);
  import bmp32_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [2:0]           status_r;
  logic [31:0]          pixel_r;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic                 last_r;
  logic [DIM_W-1:0]     width_r;
  logic [DIM_W-1:0]     height_r;
  logic [2*DIM_W-1:0]   prod;

  assign q_pop = q_valid && (!valid_r || !out_stall);
  assign prod  = q_head.drow * q_head.width;

  always_comb begin
    addr_nxt  = ADDR_W'(prod + (2 * DIM_W)'(q_head.col));
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= q_head.status;
      pixel_r  <= q_head.pixel;
      addr_r   <= addr_nxt;
      last_r   <= q_head.last;
      width_r  <= q_head.width;
      height_r <= q_head.height;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_pixel_value   = pixel_r;
  assign out_pixel_address = addr_r;
  assign out_last_pixel    = last_r;
  assign out_image_width   = width_r;
  assign out_image_height  = height_r;

endmodule

`default_nettype wire

FILE: rtl/core/bmp32_stream_decoder.sv
// bmp32 stream decoder top: one file byte per cycle in unless stalled, status or pixel results out
// a result is written into the queue when its byte is accepted, then into the output register
// throughput: one byte per cycle unless stalled, set by the byte-wide front end and a four-entry queue
// stalls on the result side reach the byte input only once the queue is full
// reset (rst_n low, synchronous) returns to the header phase at once, no clearing pass
// depends on bmp32_pkg, bmp32_front, bmp32_fifo, bmp32_back, assertion macro header
`default_nettype none

module bmp32_stream_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_end_of_file,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_status,
  output logic [31:0]                        out_pixel_value,
  output logic [bmp32_pkg::ADDR_W-1:0]       out_pixel_address,
  output logic                               out_last_pixel,
  output logic [bmp32_pkg::DIM_W-1:0]        out_image_width,
  output logic [bmp32_pkg::DIM_W-1:0]        out_image_height
);
  import bmp32_pkg::*;

  `include "bmp32_stream_decoder_assert.svh"

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  entry_t q_entry;
  entry_t q_head;

  bmp32_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  bmp32_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  bmp32_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_pixel_value   (out_pixel_value),
    .out_pixel_address (out_pixel_address),
    .out_last_pixel    (out_last_pixel),
    .out_image_width   (out_image_width),
    .out_image_height  (out_image_height)
  );

  // error results carry an all-zero payload
  `BMP32_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid && out_status != ST_PIXEL, out_pixel_value == 32'd0 && out_pixel_address == '0 && !out_last_pixel && out_image_width == '0)
  // last pixel only on a pixel result with a real image size
  `BMP32_ASSERT_IMPLY(a_last_pix, clk, rst_n, out_valid && out_last_pixel, out_status == ST_PIXEL && out_image_width != '0 && out_image_height != '0)
  // the queue is never pushed while full
  `BMP32_ASSERT_IMPLY(a_no_overflow, clk, rst_n, q_full, !q_push)
  // a popped entry shows up on the output next cycle
  `BMP32_ASSERT_NEXT(a_pop_shows, clk, rst_n, q_pop, out_valid)

endmodule

`default_nettype wire

FILE: dv/tb.sv
// testbench for bmp32_stream_decoder: bmp files as byte streams, decoded
// pixels and status codes checked against a local decoder model
// depends on bmp32_pkg and the bmp32_stream_decoder rtl
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmp32_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned RANDOM_BYTES = 150;

  typedef struct packed {
    status_t             status;
    logic [31:0]         value;
    logic [ADDR_W-1:0]   addr;
    logic                last;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
  } decoded_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic in_end_of_file = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [2:0] out_status;
  logic [31:0] out_pixel_value;
  logic [ADDR_W-1:0] out_pixel_address;
  logic out_last_pixel;
  logic [DIM_W-1:0] out_image_width;
  logic [DIM_W-1:0] out_image_height;

  bmp32_stream_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_file    (in_end_of_file),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_pixel_value   (out_pixel_value),
    .out_pixel_address (out_pixel_address),
    .out_last_pixel    (out_last_pixel),
    .out_image_width   (out_image_width),
    .out_image_height  (out_image_height)
  );

  always #6 clk = ~clk;

  // decoder model state
  phase_t      rx_phase;
  int unsigned hdr_count;
  logic [15:0] sig_f;
  logic [31:0] ofs_f;
  logic [31:0] info_f;
  logic [31:0] wid_f;
  logic [31:0] hgt_f;
  logic [15:0] planes_f;
  logic [15:0] bpp_f;
  logic [31:0] comp_f;
  logic [31:0] file_pos;
  logic [23:0] part_px;
  int unsigned px_byte;
  logic [31:0] row_cnt;
  logic [31:0] col_cnt;
  logic        flip;

  decoded_t    decoded_results_q[$];
  logic [7:0]  file_bytes[$];

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned live_bytes = 0;
  int unsigned files_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned statuses_checked = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  logic [9:0]  stall_clock = '0;
  int unsigned stall_run = 0;

  function automatic void rearm_decoder();
    rx_phase = PH_HEADER;
    hdr_count = 0;
    sig_f = '0;
    ofs_f = '0;
    info_f = '0;
    wid_f = '0;
    hgt_f = '0;
    planes_f = '0;
    bpp_f = '0;
    comp_f = '0;
    file_pos = '0;
    part_px = '0;
    px_byte = 0;
    row_cnt = '0;
    col_cnt = '0;
    flip = 1'b0;
  endfunction

  function automatic logic [31:0] abs_hgt();
    return hgt_f[31] ? (32'd0 - hgt_f) : hgt_f;
  endfunction

  function automatic decoded_t status_only(input status_t s);
    decoded_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  function automatic bit decode_file_byte(input logic [7:0] b, input bit eof,
                                          output decoded_t r);
    int unsigned idx;
    logic [31:0] h;
    logic [31:0] drow;
    logic [31:0] addr;
    logic [31:0] pix;
    bit lastp;
    bit produced;
    status_t verdict;
    produced = 1'b0;
    r = '0;
    case (rx_phase)
      PH_HEADER: begin
        idx = hdr_count;
        if (idx < 2) sig_f[8*idx +: 8] = b;
        else if (idx >= OFS_BASE && idx < OFS_BASE + 4) ofs_f[8*(idx-OFS_BASE) +: 8] = b;
        else if (idx >= INFO_BASE && idx < INFO_BASE + 4) info_f[8*(idx-INFO_BASE) +: 8] = b;
        else if (idx >= WID_BASE && idx < WID_BASE + 4) wid_f[8*(idx-WID_BASE) +: 8] = b;
        else if (idx >= HGT_BASE && idx < HGT_BASE + 4) hgt_f[8*(idx-HGT_BASE) +: 8] = b;
        else if (idx >= PLN_BASE && idx < PLN_BASE + 2) planes_f[8*(idx-PLN_BASE) +: 8] = b;
        else if (idx >= BPP_BASE && idx < BPP_BASE + 2) bpp_f[8*(idx-BPP_BASE) +: 8] = b;
        else if (idx >= CMP_BASE && idx < CMP_BASE + 4) comp_f[8*(idx-CMP_BASE) +: 8] = b;
        hdr_count++;
        file_pos = hdr_count;
        if (hdr_count < HDR_BYTES) begin
          if (eof) begin
            r = status_only(ST_TRUNC);
            produced = 1'b1;
          end
        end else begin
          if (sig_f != SIG_BM) verdict = ST_SIG;
          else if (info_f < INFO_MIN || planes_f != 16'd1 || bpp_f != BPP_32) verdict = ST_HDR;
          else if (wid_f[31] || wid_f == 0 || hgt_f == 0) verdict = ST_DIM;
          else if (comp_f != 0) verdict = ST_COMP;
          else if (wid_f > MAX_WIDTH || abs_hgt() > MAX_HEIGHT) verdict = ST_BIG;
          else if (ofs_f < HDR_BYTES) verdict = ST_OFS;
          else verdict = ST_PIXEL;
          if (verdict != ST_PIXEL) begin
            r = status_only(verdict);
            produced = 1'b1;
            rx_phase = PH_DRAIN;
          end else begin
            flip = !hgt_f[31];
            rx_phase = (file_pos >= ofs_f) ? PH_PIXEL : PH_SKIP;
            if (eof) begin
              r = status_only(ST_TRUNC);
              produced = 1'b1;
            end
          end
        end
      end
      PH_SKIP: begin
        file_pos++;
        if (file_pos >= ofs_f) rx_phase = PH_PIXEL;
        if (eof) begin
          r = status_only(ST_TRUNC);
          produced = 1'b1;
        end
      end
      PH_PIXEL: begin
        if (px_byte < 3) begin
          part_px[8*px_byte +: 8] = b;
          px_byte++;
          if (eof) begin
            r = status_only(ST_TRUNC);
            produced = 1'b1;
          end
        end else begin
          h = abs_hgt();
          pix = {b, part_px};
          drow = flip ? (h - 32'd1 - row_cnt) : row_cnt;
          addr = drow * wid_f + col_cnt;
          lastp = (row_cnt + 32'd1 == h) && (col_cnt + 32'd1 == wid_f);
          part_px = '0;
          px_byte = 0;
          if (col_cnt + 32'd1 >= wid_f) begin
            col_cnt = '0;
            row_cnt++;
          end else begin
            col_cnt++;
          end
          if (eof && !lastp) begin
            r = status_only(ST_TRUNC);
          end else begin
            r.status = ST_PIXEL;
            r.value = pix;
            r.addr = addr[ADDR_W-1:0];
            r.last = lastp;
            r.width = wid_f[DIM_W-1:0];
            r.height = h[DIM_W-1:0];
            if (lastp) rx_phase = PH_DRAIN;
          end
          produced = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (eof) rearm_decoder();
    return produced;
  endfunction

  // receiver stall pattern, mode picked by the top bits of stall_clock
  always @(posedge clk) begin
    stall_clock <= stall_clock + 10'd1;
    case (stall_clock[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: begin
        if (stall_run != 0) begin
          stall_run <= stall_run - 1;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_run <= $urandom_range(1, 8);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
      default: out_stall <= (stall_clock[1:0] != 2'd0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    decoded_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_results_q.size() == 0) begin
        $error("unexpected result: status %0d pixel %h", out_status, out_pixel_value);
        errors++;
      end else begin
        exp_r = decoded_results_q.pop_front();
        if (exp_r.status == ST_PIXEL) pixels_checked++;
        else statuses_checked++;
        if (out_status !== exp_r.status) begin
          $error("out_status: expected %0d, got %0d", exp_r.status, out_status);
          errors++;
        end
        if (out_pixel_value !== exp_r.value) begin
          $error("out_pixel_value: expected %h, got %h", exp_r.value, out_pixel_value);
          errors++;
        end
        if (out_pixel_address !== exp_r.addr) begin
          $error("out_pixel_address: expected %0d, got %0d", exp_r.addr, out_pixel_address);
          errors++;
        end
        if (out_last_pixel !== exp_r.last) begin
          $error("out_last_pixel: expected %0d, got %0d", exp_r.last, out_last_pixel);
          errors++;
        end
        if (out_image_width !== exp_r.width) begin
          $error("out_image_width: expected %0d, got %0d", exp_r.width, out_image_width);
          errors++;
        end
        if (out_image_height !== exp_r.height) begin
          $error("out_image_height: expected %0d, got %0d", exp_r.height, out_image_height);
          errors++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit eof);
    decoded_t r;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    if (rx_phase != PH_DRAIN) live_bytes++;
    if (decode_file_byte(b, eof, r)) decoded_results_q.push_back(r);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // end flag goes on the last byte of the buffer
  task automatic send_buffer();
    files_sent++;
    for (int i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic trim_to(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  task automatic build_header(input logic [15:0] sig, input logic [31:0] ofs,
                              input logic [31:0] info, input logic [31:0] w,
                              input logic [31:0] h, input logic [15:0] planes,
                              input logic [15:0] bpp, input logic [31:0] comp);
    file_bytes.delete();
    put_le({16'd0, sig}, 2);
    add_random(8);
    put_le(ofs, 4);
    put_le(info, 4);
    put_le(w, 4);
    put_le(h, 4);
    put_le({16'd0, planes}, 2);
    put_le({16'd0, bpp}, 2);
    put_le(comp, 4);
    add_random(20);
  endtask

  task automatic add_image(input int w, input int h, input int ofs);
    int absh;
    absh = (h < 0) ? -h : h;
    build_header(SIG_BM, ofs, INFO_MIN + $urandom_range(0, 88), w, h, 16'd1, BPP_32, '0);
    add_random(ofs - HDR_BYTES);
    add_random(4 * w * absh);
  endtask

  task automatic reject_case(input logic [15:0] sig, input logic [31:0] ofs,
                             input logic [31:0] info, input logic [31:0] w,
                             input logic [31:0] h, input logic [15:0] planes,
                             input logic [15:0] bpp, input logic [31:0] comp);
    build_header(sig, ofs, info, w, h, planes, bpp, comp);
    add_random($urandom_range(0, 6));
    send_buffer();
  endtask

  task automatic test_truncated_headers();
    file_bytes.delete();
    add_random(1);
    send_buffer();
    add_image(2, -2, 54);
    trim_to(HDR_BYTES);
    send_buffer();
    add_image(1, 1, 60);
    trim_to(57);
    send_buffer();
  endtask

  task automatic test_header_rejects();
    reject_case(16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'd1);
    reject_case(SIG_BM, 32'd0, 32'd39, 32'd0, 32'd0, 16'd1, BPP_32, 32'd1);
    reject_case(SIG_BM, 32'd0, INFO_MIN, 32'h8000_0000, 32'd1, 16'd1, BPP_32, 32'd1);
    reject_case(SIG_BM, 32'd0, INFO_MIN, 32'd1025, 32'd1, 16'd1, BPP_32, 32'd1);
    reject_case(SIG_BM, 32'd53, INFO_MIN, 32'd1025, 32'd1, 16'd1, BPP_32, '0);
    reject_case(SIG_BM, 32'd54, INFO_MIN, 32'd1, 32'h8000_0000, 16'd1, BPP_32, '0);
    reject_case(SIG_BM, 32'd53, INFO_MIN, 32'd1, 32'd1, 16'd1, BPP_32, '0);
    // error on the 54th byte together with the end flag
    build_header(SIG_BM, 32'd54, INFO_MIN, 32'd0, 32'd1, 16'd1, BPP_32, '0);
    send_buffer();
  endtask

  task automatic test_small_images();
    add_image(1, -1, 54);
    add_random(3);
    send_buffer();
    add_image(2, 2, 58);
    send_buffer();
  endtask

  task automatic test_largest_images();
    // end flag inside the third pixel
    add_image(MAX_WIDTH, 2, 54);
    trim_to(HDR_BYTES + 9);
    send_buffer();
    // end flag on a completed pixel that is not the last one
    add_image(1, MAX_HEIGHT, 54);
    trim_to(HDR_BYTES + 8);
    send_buffer();
  endtask

  task automatic test_random_files();
    int unsigned start_count;
    int unsigned kind;
    int unsigned ending;
    int w;
    int h;
    int ofs;
    logic [15:0] sig;
    logic [15:0] planes;
    logic [15:0] bpp;
    logic [31:0] info;
    logic [31:0] wf;
    logic [31:0] hf;
    logic [31:0] of;
    logic [31:0] comp;
    start_count = live_bytes;
    while (live_bytes - start_count < RANDOM_BYTES) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 3);
        if ($urandom_range(0, 1) == 1) h = -h;
        ofs = HDR_BYTES + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
        add_image(w, h, ofs);
        ending = $urandom_range(0, 9);
        if (ending == 7) add_random($urandom_range(1, 8));
        else if (ending >= 8) trim_to($urandom_range(1, file_bytes.size() - 1));
      end else if (kind <= 8) begin
        sig = SIG_BM;
        of = HDR_BYTES;
        info = INFO_MIN;
        wf = $urandom_range(1, 4);
        hf = $urandom_range(1, 3);
        planes = 16'd1;
        bpp = BPP_32;
        comp = '0;
        case ($urandom_range(0, 7))
          0: sig = 16'($urandom());
          1: info = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 39) : $urandom();
          2: planes = 16'($urandom());
          3: bpp = 16'($urandom());
          4: wf = ($urandom_range(0, 1) == 1) ? 32'd0 : $urandom();
          5: hf = ($urandom_range(0, 1) == 1) ? 32'd0 : $urandom();
          6: comp = $urandom();
          default: of = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 53) : $urandom();
        endcase
        if ($urandom_range(0, 3) == 0) begin
          sig[$urandom_range(0, 15)] ^= 1'b1;
          of = $urandom();
        end
        build_header(sig, of, info, wf, hf, planes, bpp, comp);
        add_random($urandom_range(0, 10));
      end else begin
        file_bytes.delete();
        add_random($urandom_range(1, 80));
      end
      send_buffer();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rearm_decoder();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_truncated_headers();
    test_header_rejects();
    test_small_images();
    test_largest_images();
    test_random_files();
    if (in_valid) in_valid <= 1'b0;
    while (decoded_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("tb: %0d files, %0d bytes sent (%0d outside the drain phase)",
             files_sent, bytes_sent, live_bytes);
    $display("tb: %0d pixel results and %0d status results compared",
             pixels_checked, statuses_checked);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: bmp32_stream_decoder.f
+incdir+rtl/core
rtl/core/bmp32_pkg.sv
rtl/core/bmp32_front.sv
rtl/core/bmp32_fifo.sv
rtl/core/bmp32_back.sv
rtl/core/bmp32_stream_decoder.sv
dv/tb.sv
